### rtl/core/iib_pkg.sv
// package for the integral image builder
// shared widths, configuration register indexes and the position flags struct; no dependencies
package iib_pkg;

    localparam int SUM_W     = 36;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    // position marks of one pixel, passed from the raster counters to the pipeline
    typedef struct packed {
        logic row_nz;
        logic eol;
        logic eof;
    } t_pos_flags;

endpackage

### rtl/core/iib_ctrl.sv
// raster counters, geometry registers and current-row running sum
// depends on iib_pkg
module iib_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int ROW_W      = 36
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [iib_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iib_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic [PIXEL_BITS-1:0]         i_pixel,
    output logic [COL_W-1:0]              o_col,
    output iib_pkg::t_pos_flags           o_flags,
    output logic [ROW_W-1:0]              o_row_sum
);

    localparam int LINE_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0]  r_w_last;
    logic [LINE_W-1:0] r_h_last;
    logic [COL_W-1:0]  r_col;
    logic [LINE_W-1:0] r_row;
    logic [ROW_W-1:0]  r_row_sum;
    logic [COL_W-1:0]  n_w_last;
    logic [LINE_W-1:0] n_h_last;
    logic [COL_W-1:0]  n_col;
    logic [LINE_W-1:0] n_row;
    logic [ROW_W-1:0]  n_row_sum;
    logic              eol;
    logic              eof;

    // last column / row index from a written dimension, zero reads as one
    always_comb begin
        if (i_cfg_data == '0) begin
            n_w_last = '0;
            n_h_last = '0;
        end else begin
            if (32'(i_cfg_data) > MAX_WIDTH) begin
                n_w_last = COL_W'(MAX_WIDTH - 1);
            end else begin
                n_w_last = COL_W'(i_cfg_data - 1'b1);
            end
            if (32'(i_cfg_data) > MAX_HEIGHT) begin
                n_h_last = LINE_W'(MAX_HEIGHT - 1);
            end else begin
                n_h_last = LINE_W'(i_cfg_data - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= COL_W'(32'(iib_pkg::WIDTH_RESET) - 1);
            r_h_last <= LINE_W'(32'(iib_pkg::HEIGHT_RESET) - 1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == iib_pkg::CFG_IDX_WIDTH) begin
                r_w_last <= n_w_last;
            end
            if (i_cfg_idx == iib_pkg::CFG_IDX_HEIGHT) begin
                r_h_last <= n_h_last;
            end
        end
    end

    // a counter left past the end by a geometry change still ends the line
    assign eol = (r_col >= r_w_last);
    assign eof = eol && (r_row >= r_h_last);

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_row_sum = r_row_sum;
        if (i_accept) begin
            if (r_col == '0) begin
                n_row_sum = ROW_W'(i_pixel);
            end else begin
                n_row_sum = r_row_sum + ROW_W'(i_pixel);
            end
            if (eol) begin
                n_col = '0;
                n_row = eof ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_row_sum <= '0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_row_sum <= n_row_sum;
        end
    end

    assign o_col          = r_col;
    assign o_flags.row_nz = (r_row != '0);
    assign o_flags.eol    = eol;
    assign o_flags.eof    = eof;
    // running sum of the current row up to and including the most recently accepted pixel
    assign o_row_sum      = r_row_sum;

endmodule

### rtl/core/iib_line_mem.sv
// line store of the previous row's integrals: one write port, one read port
// read data registered, held between read enables; depends on nothing
module iib_line_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 36,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/integral_image_builder_top.sv
// top level of the integral image builder
// depends on iib_pkg, iib_ctrl, iib_line_mem
//
// Pixels enter in raster order on the input channel (i_in_valid / o_in_ready,
// i_pixel_value), one request per pixel. Each pixel gives one result on the
// output channel (o_out_valid / i_out_ready): the 36-bit inclusive sum above
// and left, with end-of-line and end-of-frame marks.
// Geometry is set through the write port (index 0 width, index 1 height,
// zero counts as one, values above the maximum saturate); write it only while
// no request is in flight.
// Stages: an accepted pixel passes the adder stage, then the output register.
// Throughput: one pixel per clock while the receiver takes results, set by the
// single read port and the single write port of the line store, which is read
// when a pixel is accepted and written when it leaves the adder stage; a column
// read while its write is still in the adder stage is forwarded.
// Reset clears the counters, the row sum and both pipeline valids; the line
// store needs no clearing, since row 0 ignores the data read from it.
// When the receiver stalls, the output register holds and one more pixel
// waits in the adder stage; input ready then drops until the output moves.
module integral_image_builder_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [iib_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [iib_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [PIXEL_BITS-1:0]         i_pixel_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [iib_pkg::SUM_W-1:0]     o_integral_sum,
    output logic                          o_end_of_line,
    output logic                          o_end_of_frame
);

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_FULL = PIXEL_BITS + COL_W;
    localparam int ROW_W    = (ROW_FULL > iib_pkg::SUM_W) ? iib_pkg::SUM_W : ROW_FULL;
    localparam int SUM_W    = iib_pkg::SUM_W;

    logic                accept;
    logic                c_move;
    logic                hazard;
    logic [COL_W-1:0]    cur_col;
    iib_pkg::t_pos_flags cur_flags;
    logic [ROW_W-1:0]    row_sum;
    logic [SUM_W-1:0]    mem_rdata;
    logic [SUM_W-1:0]    above;
    logic [SUM_W-1:0]    b_sum;

    logic                r_b_valid;
    logic [COL_W-1:0]    r_b_col;
    iib_pkg::t_pos_flags r_b_flags;
    logic                r_b_fwd;
    logic [SUM_W-1:0]    r_fwd_sum;
    logic                r_c_valid;
    logic [SUM_W-1:0]    r_c_sum;
    logic                r_c_eol;
    logic                r_c_eof;

    assign c_move     = r_b_valid && (!r_c_valid || i_out_ready);
    assign o_in_ready = !r_b_valid || c_move;
    assign accept     = i_in_valid && o_in_ready;
    // the adder stage writes this column at the same edge as the new read
    assign hazard     = r_b_valid && (r_b_col == cur_col);

    iib_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_pixel    (i_pixel_value),
        .o_col      (cur_col),
        .o_flags    (cur_flags),
        .o_row_sum  (row_sum)
    );

    iib_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .WIDTH  (SUM_W),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (c_move),
        .i_waddr (r_b_col),
        .i_wdata (b_sum),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        if (!r_b_flags.row_nz) begin
            above = '0;
        end else if (r_b_fwd) begin
            above = r_fwd_sum;
        end else begin
            above = mem_rdata;
        end
        b_sum = SUM_W'(SUM_W'(row_sum) + above);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_b_valid <= 1'b1;
            end else if (c_move) begin
                r_b_valid <= 1'b0;
            end
            if (c_move) begin
                r_c_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_c_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_col   <= cur_col;
            r_b_flags <= cur_flags;
            r_b_fwd   <= hazard;
            r_fwd_sum <= b_sum;
        end
        if (c_move) begin
            r_c_sum <= b_sum;
            r_c_eol <= r_b_flags.eol;
            r_c_eof <= r_b_flags.eof;
        end
    end

    assign o_out_valid    = r_c_valid;
    assign o_integral_sum = r_c_sum;
    assign o_end_of_line  = r_c_eol;
    assign o_end_of_frame = r_c_eof;

endmodule

### rtl/core/iib_checker.sv
// port-level checks for the integral image builder, bound to the top level
// depends on iib_pkg
module iib_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [iib_pkg::SUM_W-1:0] o_integral_sum,
    input logic                      o_end_of_line,
    input logic                      o_end_of_frame
);

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output request dropped while stalled");

    a_sum_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_integral_sum))
        else $error("output sum changed while stalled");

    a_eof_eol : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_frame |-> o_end_of_line)
        else $error("end of frame without end of line");

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind integral_image_builder_top iib_checker u_iib_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_integral_sum (o_integral_sum),
    .o_end_of_line  (o_end_of_line),
    .o_end_of_frame (o_end_of_frame)
);

### tb/tb_integral_image_builder_top.sv
// testbench for integral_image_builder_top: directed table, then random frames
// depends on iib_pkg and the integral image builder rtl
`timescale 1ns / 1ps

module tb_integral_image_builder_top;

    localparam int LINE_LEN     = 1024;
    localparam int FRAME_ROWS   = 1024;
    localparam int PIX_W        = 16;
    localparam int RANDOM_ITEMS = 1700;

    localparam int SUM_W     = iib_pkg::SUM_W;
    localparam int CFG_W     = iib_pkg::CFG_W;
    localparam int CFG_IDX_W = iib_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = iib_pkg::CFG_IDX_WIDTH;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = iib_pkg::CFG_IDX_HEIGHT;

    // indexes past the two registers, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             eol;
        logic             eof;
    } t_sum_rec;

    typedef enum logic {ROW_PIXEL, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [PIX_W-1:0]     value;
        logic                 fixed;
        t_sum_rec             want;
    } t_dir_row;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_WAVE} t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [PIX_W-1:0]     i_pixel_value;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [SUM_W-1:0]     o_integral_sum;
    logic                 o_end_of_line;
    logic                 o_end_of_frame;

    integral_image_builder_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_value  (i_pixel_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_integral_sum (o_integral_sum),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame)
    );

    always #1 i_clk = ~i_clk;

    // shadow of the block's geometry and raster state
    logic [CFG_W-1:0] width_reg  = iib_pkg::WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = iib_pkg::HEIGHT_RESET;
    logic [SUM_W-1:0] cur_row_sum = '0;
    logic [SUM_W-1:0] line_store [LINE_LEN];
    bit               line_written [LINE_LEN];
    int               col_pos = 0;
    int               row_pos = 0;

    t_sum_rec expected_sums [$];
    int       mismatches = 0;
    int       random_sent = 0;
    int       burst_left = 0;

    // directed part: reset geometry, zero and saturated sizes, spare indexes,
    // geometry changed mid-row and mid-frame
    t_dir_row directed_rows [0:27] = '{
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'hFFFF, 1'b1, '{36'd65535, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0001, 1'b1, '{36'd65536, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0000, 1'b1, '{36'd65536, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd0,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd0,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h8000, 1'b1, '{36'd98304, 1'b1, 1'b1}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'hFFFF, 1'b1, '{36'd65535, 1'b1, 1'b1}},
        '{ROW_CFG,   CFG_IDX_SPARE_A, 16'd5,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_SPARE_B, 16'd2047, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0007, 1'b1, '{36'd7, 1'b1, 1'b1}},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd2047, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd2,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'hFFFF, 1'b1, '{36'd65535, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd2,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0001, 1'b1, '{36'd65536, 1'b1, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0100, 1'b1, '{36'd65791, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0002, 1'b1, '{36'd65794, 1'b1, 1'b1}},
        '{ROW_CFG,   CFG_IDX_WIDTH,   16'd3,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd3,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'hAAAA, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h5555, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'hFFFF, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0000, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd1,    1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h1234, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'h0001, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_CFG,   CFG_IDX_HEIGHT,  16'd2047, 1'b0, '{36'd0, 1'b0, 1'b0}},
        '{ROW_PIXEL, CFG_IDX_WIDTH,   16'hFFFF, 1'b0, '{36'd0, 1'b0, 1'b0}}
    };

    function automatic int eff_dim(input logic [CFG_W-1:0] raw, input int limit);
        if (raw == '0) return 1;
        if (int'(raw) > limit) return limit;
        return int'(raw);
    endfunction

    function automatic t_sum_rec predict_integral(input logic [PIX_W-1:0] pix);
        t_sum_rec         res;
        int               w;
        int               h;
        int               col;
        logic [SUM_W-1:0] above;
        w = eff_dim(width_reg, LINE_LEN);
        h = eff_dim(height_reg, FRAME_ROWS);
        col = (col_pos >= LINE_LEN) ? LINE_LEN - 1 : col_pos;
        cur_row_sum = (col_pos == 0) ? SUM_W'(pix) : cur_row_sum + SUM_W'(pix);
        above = (row_pos != 0) ? line_store[col] : '0;
        res.sum = cur_row_sum + above;
        line_store[col] = res.sum;
        line_written[col] = 1'b1;
        res.eol = (col_pos >= w - 1);
        res.eof = res.eol && (row_pos >= h - 1);
        if (res.eol) begin
            col_pos = 0;
            row_pos = res.eof ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return CFG_W'(1);
        if (r < 60) return CFG_W'($urandom_range(2, 6));
        if (r < 85) return CFG_W'($urandom_range(7, 40));
        if (r < 93) return CFG_W'($urandom_range(41, 200));
        return CFG_W'($urandom_range(1025, 2047));
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PIX_W'($urandom_range(0, 255));
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [SUM_W-1:0] want,
                                 input logic [SUM_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endtask

    // called just after a rising edge; returns at the edge that took the request
    task automatic offer_pixel(input logic [PIX_W-1:0] pix, input logic fixed,
                               input t_sum_rec want);
        t_sum_rec predicted;
        i_in_valid    <= 1'b1;
        i_pixel_value <= pix;
        do @(negedge i_clk); while (!o_in_ready);
        predicted = predict_integral(pix);
        expected_sums.push_back(fixed ? want : predicted);
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_sums.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IDX_WIDTH)
            width_reg = data;
        else if (idx == CFG_IDX_HEIGHT)
            height_reg = data;
        @(posedge i_clk);
    endtask

    // pixels in bursts with random gaps, now and then draining the pipe first
    task automatic send_run(input int count);
        int gap;
        repeat (count) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if ($urandom_range(0, 39) == 0) begin
                    wait_idle();
                end else if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            offer_pixel(rand_pixel(), 1'b0, '0);
            burst_left--;
            random_sent++;
        end
    endtask

    // receiver stalls: open, light, heavy and square wave stretches
    initial begin : receiver
        t_rx_mode mode;
        int       left;
        int       half;
        int       cyc;
        i_out_ready = 1'b0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            left = $urandom_range(32, 400);
            half = $urandom_range(1, 12);
            for (cyc = 0; cyc < left; cyc++) begin
                @(posedge i_clk);
                case (mode)
                    RX_OPEN:  i_out_ready <= 1'b1;
                    RX_LIGHT: i_out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: i_out_ready <= ($urandom_range(0, 3) == 0);
                    default:  i_out_ready <= ((cyc / half) % 2 == 0);
                endcase
            end
        end
    end

    always @(negedge i_clk) begin
        t_sum_rec want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_sums.size() == 0) begin
                flag_mismatch("result with nothing expected", '0, o_integral_sum);
            end else begin
                want = expected_sums.pop_front();
                if (o_integral_sum !== want.sum)
                    flag_mismatch("integral_sum", want.sum, o_integral_sum);
                if (o_end_of_line !== want.eol)
                    flag_mismatch("end_of_line", SUM_W'(want.eol), SUM_W'(o_end_of_line));
                if (o_end_of_frame !== want.eof)
                    flag_mismatch("end_of_frame", SUM_W'(want.eof), SUM_W'(o_end_of_frame));
            end
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] w_raw;
        bit               safe;
        bit               wide_done;
        int               lim;
        int               c;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_IDX_WIDTH;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_pixel_value = '0;
        wide_done     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed_rows[i].idx, directed_rows[i].value[CFG_W-1:0]);
            end else begin
                offer_pixel(directed_rows[i].value, directed_rows[i].fixed,
                            directed_rows[i].want);
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            if (!wide_done && random_sent > 400) begin
                // close the frame with a single pixel, then one full 1024-pixel row
                write_reg(CFG_IDX_WIDTH, CFG_W'(1));
                write_reg(CFG_IDX_HEIGHT, CFG_W'(1));
                offer_pixel(rand_pixel(), 1'b0, '0);
                wait_idle();
                write_reg(CFG_IDX_WIDTH, CFG_W'(2047));
                write_reg(CFG_IDX_HEIGHT, CFG_W'(1));
                send_run(LINE_LEN);
                wide_done = 1'b1;
            end else begin
                // a wider line must not reach line store columns never written
                w_raw = pick_dim();
                safe  = 1'b1;
                if (row_pos != 0) begin
                    lim = eff_dim(w_raw, LINE_LEN) - 1;
                    if (lim < col_pos) lim = col_pos;
                    for (c = col_pos; c <= lim; c++)
                        if (!line_written[c]) safe = 1'b0;
                end
                if (!safe) w_raw = width_reg;
                if ($urandom_range(0, 4) != 0) write_reg(CFG_IDX_WIDTH, w_raw);
                if ($urandom_range(0, 4) != 0) write_reg(CFG_IDX_HEIGHT, pick_dim());
                if ($urandom_range(0, 5) == 0)
                    write_reg(($urandom_range(0, 1) == 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                              CFG_W'($urandom));
                send_run($urandom_range(5, 120));
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
